// ===== rtl/core/utc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types, constants and the glyph lookup for the UTF-8 to CP437 stream.
// ----------------------------------------------------------------------------
package utc_pkg;

   localparam int CP_W = 21;

   localparam logic [7:0] QMARK      = 8'h3F;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // Results produced by one request byte: up to two characters.
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] char0;
      logic [7:0] char1;
   } dec_out_type;

   function automatic logic [7:0] map_code_point(input logic [CP_W-1:0] cp);
      logic [7:0] glyph;
      glyph = QMARK;
      if (cp < 21'h80) begin
         glyph = cp[7:0];
      end else begin
         case (cp)
            21'h2500: glyph = 8'hC4;
            21'h2502: glyph = 8'hB3;
            21'h250C: glyph = 8'hDA;
            21'h2510: glyph = 8'hBF;
            21'h2514: glyph = 8'hC0;
            21'h2518: glyph = 8'hD9;
            21'h251C: glyph = 8'hC3;
            21'h2524: glyph = 8'hB4;
            21'h252C: glyph = 8'hC2;
            21'h2534: glyph = 8'hC1;
            21'h253C: glyph = 8'hC5;
            21'h2550: glyph = 8'hCD;
            21'h2551: glyph = 8'hBA;
            21'h2554: glyph = 8'hC9;
            21'h2557: glyph = 8'hBB;
            21'h255A: glyph = 8'hC8;
            21'h255D: glyph = 8'hBC;
            21'h2560: glyph = 8'hCC;
            21'h2563: glyph = 8'hB9;
            21'h2566: glyph = 8'hCB;
            21'h2569: glyph = 8'hCA;
            21'h256C: glyph = 8'hCE;
            21'h2588: glyph = 8'hDB;
            21'h2584: glyph = 8'hDC;
            21'h2580: glyph = 8'hDF;
            21'h2591: glyph = 8'hB0;
            21'h2592: glyph = 8'hB1;
            21'h2593: glyph = 8'hB2;
            21'h00C0: glyph = 8'h85;
            21'h00C1: glyph = 8'hA0;
            21'h00C2: glyph = 8'h83;
            21'h00C3: glyph = 8'hA5;
            21'h00C7: glyph = 8'h80;
            21'h00C8: glyph = 8'h8A;
            21'h00C9: glyph = 8'h90;
            21'h00CA: glyph = 8'h88;
            21'h00CD: glyph = 8'hA1;
            21'h00D3: glyph = 8'hA2;
            21'h00D4: glyph = 8'h93;
            21'h00D5: glyph = 8'hA4;
            21'h00DA: glyph = 8'hA3;
            21'h00E0: glyph = 8'h85;
            21'h00E1: glyph = 8'hA0;
            21'h00E2: glyph = 8'h83;
            21'h00E3: glyph = 8'hA4;
            21'h00E7: glyph = 8'h87;
            21'h00E8: glyph = 8'h8A;
            21'h00E9: glyph = 8'h82;
            21'h00EA: glyph = 8'h88;
            21'h00ED: glyph = 8'hA1;
            21'h00F3: glyph = 8'hA2;
            21'h00F4: glyph = 8'h93;
            21'h00F5: glyph = 8'hA4;
            21'h00FA: glyph = 8'hA3;
            21'h00FC: glyph = 8'h81;
            21'h00B0: glyph = 8'hF8;
            21'h00B1: glyph = 8'hF1;
            21'h00B7: glyph = 8'hFA;
            21'h03A9: glyph = 8'hEA;
            21'h221E: glyph = 8'hEC;
            21'h2264: glyph = 8'hF3;
            21'h2265: glyph = 8'hF2;
            21'h221A: glyph = 8'hFB;
            default:  glyph = QMARK;
         endcase
      end
      return glyph;
   endfunction

endpackage

// ===== rtl/core/utc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_req_if
// Request channel: one raw UTF-8 byte per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface utc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/utc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_rsp_if
// Response channel: one CP437 character per transfer, plus last marker.
// ----------------------------------------------------------------------------
interface utc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       is_last;

   modport source (output valid, output out_char, output is_last, input ready);
   modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

// ===== rtl/core/utc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_decode
// Combinational UTF-8 step: next sequence state and up to two characters.
// ----------------------------------------------------------------------------
module utc_decode (
   input  logic [7:0]               in_byte,
   input  logic [1:0]               pend,
   input  logic [utc_pkg::CP_W-1:0] partial,
   output logic [1:0]               pend_in,
   output logic [utc_pkg::CP_W-1:0] partial_in,
   output utc_pkg::dec_out_type     dec
);
   import utc_pkg::*;

   logic            is_cont;
   logic [CP_W-1:0] shifted;
   logic            lead_emit;
   logic [7:0]      lead_char;
   logic [1:0]      lead_pend;
   logic [CP_W-1:0] lead_part;

   assign is_cont = (in_byte & CONT_MASK) == CONT_TAG;
   assign shifted = {partial[CP_W-7:0], in_byte[5:0]};

   // Byte taken as the start of something new.
   always_comb begin
      lead_emit = 1'b0;
      lead_char = QMARK;
      lead_pend = 2'd0;
      lead_part = '0;
      if (!in_byte[7]) begin
         lead_emit = 1'b1;
         lead_char = in_byte;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
         lead_pend = 2'd1;
         lead_part = CP_W'(in_byte[4:0]);
      end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
         lead_pend = 2'd2;
         lead_part = CP_W'(in_byte[3:0]);
      end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
         lead_pend = 2'd3;
         lead_part = CP_W'(in_byte[2:0]);
      end else begin
         lead_emit = 1'b1;  // stray continuation or invalid lead
      end
   end

   always_comb begin
      dec.cnt    = 2'd0;
      dec.char0  = QMARK;
      dec.char1  = QMARK;
      pend_in    = lead_pend;
      partial_in = lead_part;
      if (pend != 2'd0 && is_cont) begin
         pend_in    = pend - 2'd1;
         partial_in = shifted;
         if (pend == 2'd1) begin
            dec.cnt    = 2'd1;
            dec.char0  = map_code_point(shifted);
            partial_in = '0;
         end
      end else if (pend != 2'd0) begin
         // open sequence broken: '?' then the byte again as a lead
         dec.cnt   = lead_emit ? 2'd2 : 2'd1;
         dec.char1 = lead_char;
      end else if (lead_emit) begin
         dec.cnt   = 2'd1;
         dec.char0 = lead_char;
      end
   end

endmodule

// ===== rtl/core/utf8_to_cp437_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_cp437_stream
// UTF-8 byte stream to code page 437 characters.
//
//   Channel | Dir | Payload            | Per request
//   --------+-----+--------------------+-----------------------------
//   req     | in  | in_byte[7:0]       | one UTF-8 byte
//   rsp     | out | out_char, is_last  | 0, 1 or 2 characters
//
// One byte per cycle unless rsp stalls or a pair is pending: input register, decode, two-slot result register.
// A byte that yields two characters holds the result register until its
// second character leaves, since only one character leaves per cycle.
// Reset (synchronous) clears the open sequence and both registers.
// A stalled rsp backs up into the input register and then into req.ready.
// ----------------------------------------------------------------------------
module utf8_to_cp437_stream (
   input logic       clock,
   input logic       reset,
   utc_req_if.sink   req,
   utc_rsp_if.source rsp
);
   import utc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff,  in_byte_in;
   logic [1:0]      pend_ff,     pend_in;
   logic [CP_W-1:0] part_ff,     part_in;
   logic [1:0]      res_cnt_ff,  res_cnt_in;
   logic [7:0]      res_char0_ff, res_char0_in;
   logic            res_last0_ff, res_last0_in;
   logic [7:0]      res_char1_ff, res_char1_in;

   logic            slot_free;
   logic            consume;
   logic            rsp_take;
   logic [1:0]      dec_pend;
   logic [CP_W-1:0] dec_part;
   dec_out_type     dec;

   utc_decode u_decode (
      .in_byte    (in_byte_ff),
      .pend       (pend_ff),
      .partial    (part_ff),
      .pend_in    (dec_pend),
      .partial_in (dec_part),
      .dec        (dec)
   );

   assign rsp_take  = rsp.valid && rsp.ready;
   assign slot_free = (res_cnt_ff == 2'd0) || (res_cnt_ff == 2'd1 && rsp.ready);
   assign consume   = in_valid_ff && slot_free;
   assign req.ready = !in_valid_ff || consume;

   assign rsp.valid    = res_cnt_ff != 2'd0;
   assign rsp.out_char = res_char0_ff;
   assign rsp.is_last  = res_last0_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      pend_in      = pend_ff;
      part_in      = part_ff;
      res_cnt_in   = res_cnt_ff;
      res_char0_in = res_char0_ff;
      res_last0_in = res_last0_ff;
      res_char1_in = res_char1_ff;

      if (req.ready) begin
         in_valid_in = req.valid;
         in_byte_in  = req.in_byte;
      end

      if (rsp_take) begin
         if (res_cnt_ff == 2'd2) begin
            res_cnt_in   = 2'd1;
            res_char0_in = res_char1_ff;
            res_last0_in = 1'b1;
         end else begin
            res_cnt_in = 2'd0;
         end
      end

      if (consume) begin
         pend_in      = dec_pend;
         part_in      = dec_part;
         res_cnt_in   = dec.cnt;
         res_char0_in = dec.char0;
         res_last0_in = dec.cnt == 2'd1;
         res_char1_in = dec.char1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= 2'd0;
         part_ff     <= '0;
         res_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
         part_ff     <= part_in;
         res_cnt_ff  <= res_cnt_in;
      end
      in_byte_ff   <= in_byte_in;
      res_char0_ff <= res_char0_in;
      res_last0_ff <= res_last0_in;
      res_char1_ff <= res_char1_in;
   end

   // Result register never holds more than two characters.
   a_res_cnt_range: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff != 2'd3)
      else $error("result count out of range");

   // No sequence open means no gathered bits left over.
   a_idle_partial_clear: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd0 |-> part_ff == '0)
      else $error("partial code point left without open sequence");

   // A pair always starts with the '?' of a broken sequence, not marked last.
   a_pair_head: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff == 2'd2 |-> res_char0_ff == QMARK && !res_last0_ff)
      else $error("bad first character of a pair");

   // A request byte is only dropped from the input register when decoded.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !slot_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a request");

endmodule
